[sv/pptx_pkg.sv]
package pptx_pkg;

    // fixed framing constants
    localparam logic [10:0] MIN_FRAME_LEN    = 11'd60;
    localparam logic [7:0]  SLOT_PAGE_OFFSET = 8'd6;

    // slot modes (code 3 never arises and is handled like waiting)
    localparam logic [1:0] MODE_EMPTY   = 2'd0;
    localparam logic [1:0] MODE_WAITING = 2'd1;
    localparam logic [1:0] MODE_SENDING = 2'd2;

    // operation codes
    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_DONE   = 1'b1;

    // register map: index is paddr[2]
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_BASE_PAGE = 1'b0;
    localparam logic REG_PP_EN     = 1'b1;

    localparam logic [7:0] BASE_PAGE_RST = 8'd64;
    localparam logic       PP_EN_RST     = 1'b1;

    typedef struct packed {
        logic        op;
        logic [10:0] pkt_len;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  copy_page;
        logic        start_send;
        logic [10:0] send_len;
        logic [7:0]  send_page;
        logic        busy_res;
        logic        unexpected_done;
    } t_out_word;

    typedef struct packed {
        logic [7:0] base_page;
        logic       pp_en;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FULL = 2'b10
    } t_state;

endpackage

[sv/pptx_regs.sv]
module pptx_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pptx_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output pptx_pkg::t_cfg                 o_cfg
);

    logic [7:0] r_base_page;
    logic       r_pp_en;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_page <= pptx_pkg::BASE_PAGE_RST;
            r_pp_en     <= pptx_pkg::PP_EN_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                pptx_pkg::REG_BASE_PAGE: r_base_page <= pwdata[7:0];
                pptx_pkg::REG_PP_EN:     r_pp_en     <= pwdata[0];
                default:                 r_pp_en     <= r_pp_en;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            pptx_pkg::REG_BASE_PAGE: prdata = {24'd0, r_base_page};
            pptx_pkg::REG_PP_EN:     prdata = {31'd0, r_pp_en};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg.base_page = r_base_page;
    assign o_cfg.pp_en     = r_pp_en;

endmodule

[sv/pptx_ctrl.sv]
module pptx_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output pptx_pkg::t_dp_cmd  o_cmd
);

    pptx_pkg::t_state r_state;
    pptx_pkg::t_state n_state;
    logic             take;

    // a new word may enter when the result register is empty or being drained
    assign o_in_ready  = (r_state == pptx_pkg::ST_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == pptx_pkg::ST_FULL);
    assign take        = i_in_valid && o_in_ready;
    assign o_cmd.load  = take;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pptx_pkg::ST_IDLE: begin
                if (take) n_state = pptx_pkg::ST_FULL;
            end
            pptx_pkg::ST_FULL: begin
                if (i_out_ready && !take) n_state = pptx_pkg::ST_IDLE;
            end
            default: n_state = pptx_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pptx_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/pptx_dp.sv]
module pptx_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pptx_pkg::t_dp_cmd   i_cmd,
    input  pptx_pkg::t_cfg      i_cfg,
    input  pptx_pkg::t_in_word  i_in_word,
    output pptx_pkg::t_out_word o_out_word
);

    logic [1:0]          r_a_mode, n_a_mode;
    logic [1:0]          r_b_mode, n_b_mode;
    logic [10:0]         r_a_len, n_a_len;
    logic [10:0]         r_b_len, n_b_len;
    logic                r_xmit, n_xmit;
    logic                r_busy, n_busy;
    pptx_pkg::t_out_word r_res, n_res;

    logic [10:0] padded;
    logic [7:0]  page_b;
    logic        b_waiting;

    assign padded    = (i_in_word.pkt_len < pptx_pkg::MIN_FRAME_LEN) ?
                       pptx_pkg::MIN_FRAME_LEN : i_in_word.pkt_len;
    assign page_b    = i_cfg.base_page + pptx_pkg::SLOT_PAGE_OFFSET;
    assign b_waiting = (r_b_mode != pptx_pkg::MODE_EMPTY) &&
                       (r_b_mode != pptx_pkg::MODE_SENDING);

    // slot bookkeeping for one word
    always_comb begin
        n_a_mode = r_a_mode;
        n_b_mode = r_b_mode;
        n_a_len  = r_a_len;
        n_b_len  = r_b_len;
        n_xmit   = r_xmit;
        n_busy   = r_busy;
        n_res    = '0;

        if (i_in_word.op == pptx_pkg::OP_SUBMIT) begin
            if (i_in_word.pkt_len != 11'd0 && !r_busy) begin
                if (i_cfg.pp_en) begin
                    priority if (r_a_mode == pptx_pkg::MODE_EMPTY) begin
                        n_res.accepted  = 1'b1;
                        n_res.copy_page = i_cfg.base_page;
                        n_a_len         = padded;
                        n_a_mode        = r_xmit ? pptx_pkg::MODE_WAITING
                                                 : pptx_pkg::MODE_SENDING;
                    end else if (r_b_mode == pptx_pkg::MODE_EMPTY) begin
                        n_res.accepted  = 1'b1;
                        n_res.copy_page = page_b;
                        n_b_len         = padded;
                        n_b_mode        = r_xmit ? pptx_pkg::MODE_WAITING
                                                 : pptx_pkg::MODE_SENDING;
                    end else begin
                        n_res.accepted  = 1'b0;
                    end
                    if (n_res.accepted && !r_xmit) begin
                        n_res.start_send = 1'b1;
                        n_res.send_len   = padded;
                        n_res.send_page  = n_res.copy_page;
                        n_xmit           = 1'b1;
                    end
                    if (n_res.accepted && n_a_mode != pptx_pkg::MODE_EMPTY &&
                        n_b_mode != pptx_pkg::MODE_EMPTY) begin
                        n_busy = 1'b1;
                    end
                end else begin
                    // single slot: send at once and hold off until done
                    n_res.accepted   = 1'b1;
                    n_res.copy_page  = i_cfg.base_page;
                    n_res.start_send = 1'b1;
                    n_res.send_len   = padded;
                    n_res.send_page  = i_cfg.base_page;
                    n_xmit           = 1'b1;
                    n_busy           = 1'b1;
                end
            end
        end else begin
            if (i_cfg.pp_en) begin
                priority if (r_a_mode == pptx_pkg::MODE_SENDING) begin
                    n_a_mode = pptx_pkg::MODE_EMPTY;
                    n_busy   = 1'b0;
                    if (b_waiting) begin
                        n_res.start_send = 1'b1;
                        n_res.send_len   = r_b_len;
                        n_res.send_page  = page_b;
                        n_b_mode         = pptx_pkg::MODE_SENDING;
                        n_xmit           = 1'b1;
                    end else begin
                        n_xmit = 1'b0;
                    end
                end else if (r_b_mode == pptx_pkg::MODE_SENDING) begin
                    n_b_mode = pptx_pkg::MODE_EMPTY;
                    n_busy   = 1'b0;
                    if (r_a_mode != pptx_pkg::MODE_EMPTY) begin
                        n_res.start_send = 1'b1;
                        n_res.send_len   = r_a_len;
                        n_res.send_page  = i_cfg.base_page;
                        n_a_mode         = pptx_pkg::MODE_SENDING;
                        n_xmit           = 1'b1;
                    end else begin
                        n_xmit = 1'b0;
                    end
                end else begin
                    n_res.unexpected_done = 1'b1;
                end
            end else begin
                n_xmit = 1'b0;
                n_busy = 1'b0;
            end
        end
        n_res.busy_res = n_busy;
    end

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_mode <= pptx_pkg::MODE_EMPTY;
            r_b_mode <= pptx_pkg::MODE_EMPTY;
            r_a_len  <= 11'd0;
            r_b_len  <= 11'd0;
            r_xmit   <= 1'b0;
            r_busy   <= 1'b0;
        end else if (i_cmd.load) begin
            r_a_mode <= n_a_mode;
            r_b_mode <= n_b_mode;
            r_a_len  <= n_a_len;
            r_b_len  <= n_b_len;
            r_xmit   <= n_xmit;
            r_busy   <= n_busy;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res <= n_res;
        end
    end

    assign o_out_word = r_res;

endmodule

[sv/pingpong_tx_buffer_sequencer.sv]
// channel  | dir | handshake                  | word
// ---------+-----+----------------------------+-----------------------------------
// in       | in  | i_in_valid / o_in_ready    | i_in_word  (op, pkt_len)
// out      | out | o_out_valid / i_out_ready  | o_out_word (accepted .. unexpected_done)
// config   | in  | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// each word is decided in the cycle it is accepted; its result is valid the next cycle
// one word per cycle while the output is drained; a word can enter in the cycle its
// predecessor's result is taken, set by the single output register
// synchronous active-low reset empties both slots and loads register reset values
// a stalled output holds its result and blocks further input
module pingpong_tx_buffer_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pptx_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pptx_pkg::t_out_word           o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pptx_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    pptx_pkg::t_cfg    cfg;
    pptx_pkg::t_dp_cmd cmd;

    pptx_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pptx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    pptx_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

[sv/pptx_checker.sv]
module pptx_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input pptx_pkg::t_out_word  o_out_word
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // no input is taken while a result is stuck
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while output stalled");

    // a stray done neither accepts nor starts a send
    a_stray_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.unexpected_done |->
            !o_out_word.accepted && !o_out_word.start_send)
        else $error("stray done with side effects");

    // a started send is at least one minimum frame long
    a_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.start_send |->
            o_out_word.send_len >= pptx_pkg::MIN_FRAME_LEN)
        else $error("send shorter than minimum frame");

    // send fields are zero when nothing is started
    a_idle_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.start_send |->
            o_out_word.send_len == 11'd0 && o_out_word.send_page == 8'd0)
        else $error("send fields set without a send");

endmodule

bind pingpong_tx_buffer_sequencer pptx_checker u_pptx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
